// ===== design/mce_pkg.sv =====
// Shared types, constants and the Morse pattern table for the character encoder.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mce_pkg;

  localparam int CharW = 8;
  localparam int UnitW = 4;
  localparam int LenW  = 3;
  localparam int PatW  = 4;
  localparam int SegW  = 4;
  localparam int CfgIdxW = 2;

  localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CharW-1:0] CHAR_A     = 8'h61;
  localparam logic [CharW-1:0] CHAR_Z     = 8'h7a;

  localparam logic [CfgIdxW-1:0] REG_DASH_UNITS       = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LETTER_GAP_UNITS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_WORD_GAP_UNITS   = 2'd2;

  localparam logic [UnitW-1:0] RST_DASH_UNITS       = 4'd3;
  localparam logic [UnitW-1:0] RST_LETTER_GAP_UNITS = 4'd2;
  localparam logic [UnitW-1:0] RST_WORD_GAP_UNITS   = 4'd6;
  localparam logic [UnitW-1:0] DOT_UNITS            = 4'd1;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_SPACE  = 2'd1,
    KIND_BAD    = 2'd2
  } mce_kind_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
  } mce_pattern_t;

  typedef struct packed {
    mce_kind_t       kind;
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
  } mce_cmd_t;

  typedef struct packed {
    logic [UnitW-1:0] dash_units;
    logic [UnitW-1:0] letter_gap_units;
    logic [UnitW-1:0] word_gap_units;
  } mce_cfg_t;

  // Element bit i set means element i is a dash.
  function automatic mce_pattern_t morse_pattern(input logic [4:0] idx);
    mce_pattern_t p;
    unique case (idx)
      5'd0:  p = '{3'd2, 4'h2};
      5'd1:  p = '{3'd4, 4'h1};
      5'd2:  p = '{3'd4, 4'h5};
      5'd3:  p = '{3'd3, 4'h1};
      5'd4:  p = '{3'd1, 4'h0};
      5'd5:  p = '{3'd4, 4'h4};
      5'd6:  p = '{3'd3, 4'h3};
      5'd7:  p = '{3'd4, 4'h0};
      5'd8:  p = '{3'd2, 4'h0};
      5'd9:  p = '{3'd4, 4'he};
      5'd10: p = '{3'd3, 4'h5};
      5'd11: p = '{3'd4, 4'h2};
      5'd12: p = '{3'd2, 4'h3};
      5'd13: p = '{3'd2, 4'h1};
      5'd14: p = '{3'd3, 4'h7};
      5'd15: p = '{3'd4, 4'h6};
      5'd16: p = '{3'd4, 4'hb};
      5'd17: p = '{3'd3, 4'h2};
      5'd18: p = '{3'd3, 4'h0};
      5'd19: p = '{3'd1, 4'h1};
      5'd20: p = '{3'd3, 4'h4};
      5'd21: p = '{3'd4, 4'h8};
      5'd22: p = '{3'd3, 4'h6};
      5'd23: p = '{3'd4, 4'h9};
      5'd24: p = '{3'd4, 4'hd};
      5'd25: p = '{3'd4, 4'h3};
      default: p = '{3'd1, 4'h0};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/mce_front.sv =====
// Input side: takes character requests and classifies them into commands.
// Depends on mce_pkg for the pattern table and command type.
`timescale 1ns / 1ps
`default_nettype none

module mce_front (
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] char_code
  input  wire logic              q_full,
  output logic                   q_push,
  output mce_pkg::mce_cmd_t      q_cmd
);
  import mce_pkg::*;

  mce_pattern_t pat;
  logic [4:0]   idx;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign idx      = 5'(s_tdata - CHAR_A);
  assign pat      = morse_pattern(idx);

  always_comb begin
    q_cmd.len  = pat.len;
    q_cmd.bits = pat.bits;
    priority if (s_tdata == CHAR_SPACE) begin
      q_cmd.kind = KIND_SPACE;
    end else if (s_tdata < CHAR_A || s_tdata > CHAR_Z) begin
      q_cmd.kind = KIND_BAD;
    end else begin
      q_cmd.kind = KIND_LETTER;
    end
  end

endmodule

`default_nettype wire

// ===== design/mce_queue.sv =====
// Short command queue between the classifier and the segment sequencer.
// Depends on mce_pkg for the command type and depth constants.
`timescale 1ns / 1ps
`default_nettype none

module mce_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  mce_pkg::mce_cmd_t     push_cmd,
  output logic                  full,
  output logic                  empty,
  input  wire logic             pop,
  output mce_pkg::mce_cmd_t     head
);
  import mce_pkg::*;

  mce_cmd_t         entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QDepth));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("Queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("Queue read while empty.");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("Queue count beyond depth.");

endmodule

`default_nettype wire

// ===== design/mce_back.sv =====
// Segment sequencer: steps through one command, one segment per cycle when not stalled,
// into an output register. Depends on mce_pkg for the command and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module mce_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  mce_pkg::mce_cfg_t     cfg,
  input  wire logic             q_empty,
  input  mce_pkg::mce_cmd_t     head,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,  // [0] key_on, [4:1] duration_units, [7:5] zero
  output logic                  m_tuser,  // [0] bad_char
  output logic                  m_tlast
);
  import mce_pkg::*;

  logic [SegW-1:0]  seg;
  logic [SegW-1:0]  seg_next;
  logic [SegW-1:0]  gap_idx;
  logic             advance;
  logic             emit;
  logic             is_gap;
  logic             key_on;
  logic [UnitW-1:0] dur;
  logic             key_on_q;
  logic [UnitW-1:0] dur_q;
  logic             bad_q;
  logic             last_q;

  assign advance = !m_tvalid || m_tready;
  assign emit    = advance && !q_empty;
  assign gap_idx = {head.len, 1'b0};
  assign is_gap  = (head.kind != KIND_LETTER) || (seg == gap_idx);
  assign key_on  = (head.kind == KIND_LETTER) && !is_gap && !seg[0];
  assign q_pop   = emit && is_gap;
  assign seg_next = is_gap ? '0 : seg + 1'b1;

  always_comb begin
    unique case (head.kind)
      KIND_SPACE:  dur = cfg.word_gap_units;
      KIND_LETTER: begin
        if (is_gap) begin
          dur = cfg.letter_gap_units;
        end else if (seg[0]) begin
          dur = DOT_UNITS;
        end else begin
          dur = head.bits[seg[2:1]] ? cfg.dash_units : DOT_UNITS;
        end
      end
      default:     dur = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        seg <= seg_next;
      end
      if (advance) begin
        m_tvalid <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      key_on_q <= key_on;
      dur_q    <= dur;
      bad_q    <= (head.kind == KIND_BAD);
      last_q   <= is_gap;
    end
  end

  assign m_tdata = {3'b000, dur_q, key_on_q};
  assign m_tuser = bad_q;
  assign m_tlast = last_q;

  a_seg_in_letter: assert property (@(posedge clk) disable iff (rst)
    !q_empty && head.kind == KIND_LETTER |-> seg <= gap_idx)
    else $error("Segment counter ran past the letter gap.");
  a_seg_idle_zero: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> seg == '0)
    else $error("Segment counter not cleared between commands.");
  a_key_on_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tlast && !m_tuser)
    else $error("Key-on segment marked last or bad.");
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata[4:1] == '0)
    else $error("Bad character segment malformed.");

endmodule

`default_nettype wire

// ===== design/morse_character_encoder_unit.sv =====
// Channel   Direction  Content
// s_*       in         character request: tdata[7:0] char_code
// m_*       out        segment request: tdata key_on, duration_units; tuser bad_char; tlast
// cfg_*     in         register write: cfg_index, cfg_data
//
// Each character becomes segments, one per cycle in the sequencer while the output is not
// stalled: nine for a four-element letter, one for a space or an unknown byte; the next
// character follows with no idle segment. The two-entry command queue and the output
// register let the input keep accepting during an output stall until the queue fills.
// Reset restores the register defaults and empties the queue and output.
//
// Top level of the Morse encoder: holds the configuration registers and joins
// the classifier, queue and sequencer. Depends on mce_pkg and those modules.
`timescale 1ns / 1ps
`default_nettype none

module morse_character_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] key_on, [4:1] duration_units, [7:5] zero
  output logic             m_tuser,   // [0] bad_char
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import mce_pkg::*;

  mce_cfg_t cfg;
  mce_cmd_t push_cmd;
  mce_cmd_t head;
  logic     q_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dash_units       <= RST_DASH_UNITS;
      cfg.letter_gap_units <= RST_LETTER_GAP_UNITS;
      cfg.word_gap_units   <= RST_WORD_GAP_UNITS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DASH_UNITS:       cfg.dash_units       <= cfg_data;
        REG_LETTER_GAP_UNITS: cfg.letter_gap_units <= cfg_data;
        REG_WORD_GAP_UNITS:   cfg.word_gap_units   <= cfg_data;
        default:              cfg <= cfg;
      endcase
    end
  end

  mce_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  mce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .empty    (q_empty),
    .pop      (q_pop),
    .head     (head)
  );

  mce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .head     (head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
